@@ rtl/core/assert_macros.svh @@
// Assertion helpers. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BRW_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

`define BRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define BRW_ASSERT_ALWAYS(lbl, cond)

`define BRW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/brw_pkg.sv @@
package brw_pkg;

  localparam int FW_W    = 13;
  localparam int LINE_W  = 13;
  localparam int COL_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int PROD_W  = LINE_W + FW_W;
  localparam int LANES   = 8;

  localparam logic [FW_W-1:0] MAX_WIDTH = FW_W'(4096);
  localparam logic [3:0]      NUM_BLOCKS = 4'd12;

  localparam int MID_DEPTH   = 4;
  localparam int MID_PTR_W   = $clog2(MID_DEPTH);
  localparam int MID_COUNT_W = $clog2(MID_DEPTH + 1);
  localparam logic [MID_COUNT_W-1:0] MID_FULL = MID_COUNT_W'(MID_DEPTH);

  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_COUNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [OUT_COUNT_W-1:0] OUT_FULL = OUT_COUNT_W'(OUT_DEPTH);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH = 2'd0,
    REG_CHROMA_FMT  = 2'd1,
    REG_PIC_STRUCT  = 2'd2
  } reg_index_t;

  localparam logic [1:0] CF_NONE = 2'd0;
  localparam logic [1:0] CF_420  = 2'd1;
  localparam logic [1:0] CF_422  = 2'd2;
  localparam logic [1:0] CF_444  = 2'd3;

  localparam logic [1:0] PS_NONE   = 2'd0;
  localparam logic [1:0] PS_TOP    = 2'd1;
  localparam logic [1:0] PS_BOTTOM = 2'd2;
  localparam logic [1:0] PS_FRAME  = 2'd3;

  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_CB   = 2'd1;
  localparam logic [1:0] PLANE_CR   = 2'd2;

  localparam logic [3:0] COL_HALF = 4'd8;

  // line offsets of the lower block pair and, for bottom fields, the upper pair
  localparam logic [4:0] YOFF_TOP_LOWER    = 5'd16;
  localparam logic [4:0] YOFF_BOTTOM_UPPER = 5'd1;
  localparam logic [4:0] YOFF_BOTTOM_LOWER = 5'd17;
  localparam logic [4:0] YOFF_FRAME_LOWER  = 5'd8;
  localparam logic [4:0] YOFF_FIELD_LOWER  = 5'd1;

  typedef struct packed {
    logic [3:0]  block_index;
    logic [11:0] mb_x;
    logic [11:0] mb_y;
    logic        field_dct;
    logic        intra_block;
    logic [2:0]  row_index;
    logic [63:0] residual_left;
    logic [63:0] residual_right;
    logic [63:0] prediction_row;
  } req_t;

  typedef struct packed {
    logic [1:0]        plane_select;
    logic [ADDR_W-1:0] row_address;
    logic [63:0]       pixel_row;
  } res_t;

  typedef struct packed {
    logic [1:0]        plane;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [FW_W-1:0]   width;
    logic              intra;
    logic [63:0]       res_left;
    logic [63:0]       res_right;
    logic [63:0]       pred;
  } work_t;

  function automatic logic [1:0] plane_of_block(input logic [3:0] blk);
    logic [1:0] p;
    if (blk < 4'd4) begin
      p = PLANE_LUMA;
    end else if (blk[0]) begin
      p = PLANE_CR;
    end else begin
      p = PLANE_CB;
    end
    return p;
  endfunction

  function automatic logic [3:0] col_offset_of_block(input logic [3:0] blk);
    logic [3:0] c;
    if (blk < 4'd4) begin
      c = blk[0] ? COL_HALF : 4'd0;
    end else if (blk >= 4'd8) begin
      c = COL_HALF;
    end else begin
      c = 4'd0;
    end
    return c;
  endfunction

  function automatic logic [7:0] recon_pixel(input logic [15:0] r, input logic [7:0] p,
                                             input logic intra);
    logic [16:0] v;
    logic [7:0]  q;
    v = intra ? {r[15], r} : ({r[15], r} + {9'd0, p});
    if (v[16]) begin
      q = 8'd0;
    end else if (v[15:8] != 8'd0) begin
      q = 8'hFF;
    end else begin
      q = v[7:0];
    end
    return q;
  endfunction

endpackage

@@ rtl/core/brw_front.sv @@
`include "assert_macros.svh"

module brw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  brw_pkg::req_t          request,
  input  logic [brw_pkg::FW_W-1:0] frame_width,
  input  logic [1:0]             chroma_fmt,
  input  logic [1:0]             pic_struct,
  output logic                   work_valid,
  output brw_pkg::work_t         work,
  input  logic                   take
);

  brw_pkg::work_t                    queue_mem [brw_pkg::MID_DEPTH];
  logic [brw_pkg::MID_PTR_W-1:0]     wr_ptr;
  logic [brw_pkg::MID_PTR_W-1:0]     rd_ptr;
  logic [brw_pkg::MID_COUNT_W-1:0]   count;
  logic [brw_pkg::MID_COUNT_W-1:0]   count_next;

  logic                       accepted;
  logic                       store;
  brw_pkg::work_t             entry;
  logic [1:0]                 plane;
  logic                       chroma;
  logic                       bottom;
  logic                       xs;
  logic                       ys;
  logic                       sshift;
  logic [4:0]                 yoff;
  logic [11:0]                mx_s;
  logic [11:0]                my_s;
  logic [3:0]                 row_s;

  assign full     = (count == brw_pkg::MID_FULL);
  assign accepted = push && !full;
  assign store    = accepted && (request.block_index < brw_pkg::NUM_BLOCKS);

  always_comb begin
    plane  = brw_pkg::plane_of_block(request.block_index);
    chroma = (plane != brw_pkg::PLANE_LUMA);
    bottom = request.block_index[1];
    xs = chroma && (chroma_fmt == brw_pkg::CF_420 || chroma_fmt == brw_pkg::CF_422);
    ys = chroma && (chroma_fmt == brw_pkg::CF_420);

    priority if (pic_struct == brw_pkg::PS_TOP ||
                 pic_struct == brw_pkg::PS_BOTTOM) begin
      sshift = 1'b1;
    end else if (pic_struct == brw_pkg::PS_FRAME) begin
      if (!chroma) begin
        sshift = (chroma_fmt != brw_pkg::CF_NONE) && request.field_dct;
      end else begin
        sshift = (chroma_fmt == brw_pkg::CF_422 || chroma_fmt == brw_pkg::CF_444)
                 && request.field_dct;
      end
    end else begin
      sshift = 1'b0;
    end

    priority if (pic_struct == brw_pkg::PS_TOP) begin
      yoff = bottom ? brw_pkg::YOFF_TOP_LOWER : 5'd0;
    end else if (pic_struct == brw_pkg::PS_BOTTOM) begin
      yoff = bottom ? brw_pkg::YOFF_BOTTOM_LOWER : brw_pkg::YOFF_BOTTOM_UPPER;
    end else if (pic_struct == brw_pkg::PS_FRAME) begin
      yoff = !bottom ? 5'd0 :
             (request.field_dct ? brw_pkg::YOFF_FIELD_LOWER : brw_pkg::YOFF_FRAME_LOWER);
    end else begin
      yoff = 5'd0;
    end

    mx_s  = xs ? (request.mb_x >> 1) : request.mb_x;
    my_s  = ys ? (request.mb_y >> 1) : request.mb_y;
    row_s = sshift ? {request.row_index, 1'b0} : {1'b0, request.row_index};

    entry.plane     = plane;
    entry.line      = brw_pkg::LINE_W'(my_s) + brw_pkg::LINE_W'(yoff)
                    + brw_pkg::LINE_W'(row_s);
    entry.col       = brw_pkg::COL_W'(mx_s)
                    + brw_pkg::COL_W'(brw_pkg::col_offset_of_block(request.block_index));
    entry.width     = (frame_width > brw_pkg::MAX_WIDTH) ? brw_pkg::MAX_WIDTH : frame_width;
    entry.intra     = request.intra_block;
    entry.res_left  = request.residual_left;
    entry.res_right = request.residual_right;
    entry.pred      = request.prediction_row;
  end

  always_ff @(posedge clk) begin
    if (store) begin
      queue_mem[wr_ptr] <= entry;
    end
  end

  always_comb begin
    unique case ({store, take})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  assign work_valid = (count != '0);
  assign work       = queue_mem[rd_ptr];

  `BRW_ASSERT_ALWAYS(a_mid_bound, count <= brw_pkg::MID_FULL)
  `BRW_ASSERT_NEXT(a_mid_store, store && !take, count == $past(count) + 1'b1)
  `BRW_ASSERT_NEXT(a_mid_drop, accepted && !store && !take, $stable(count))

endmodule

@@ rtl/core/brw_back.sv @@
`include "assert_macros.svh"

module brw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           work_valid,
  input  brw_pkg::work_t work,
  output logic           take,
  output logic           empty,
  input  logic           pop,
  output brw_pkg::res_t  result
);

  logic                              s1_valid;
  logic [1:0]                        s1_plane;
  logic [brw_pkg::PROD_W-1:0]        s1_prod;
  logic [brw_pkg::COL_W-1:0]         s1_col;
  logic [63:0]                       s1_pix;

  brw_pkg::res_t                     out_mem [brw_pkg::OUT_DEPTH];
  logic [brw_pkg::OUT_PTR_W-1:0]     out_wr;
  logic [brw_pkg::OUT_PTR_W-1:0]     out_rd;
  logic [brw_pkg::OUT_COUNT_W-1:0]   out_count;
  logic [brw_pkg::OUT_COUNT_W-1:0]   out_count_next;

  logic                              deq;
  logic [63:0]                       pix;
  brw_pkg::res_t                     fill;

  // credit: room for everything in flight
  assign take = work_valid &&
                ((out_count + brw_pkg::OUT_COUNT_W'(s1_valid)) < brw_pkg::OUT_FULL);
  assign deq  = pop && !empty;

  always_comb begin
    for (int j = 0; j < brw_pkg::LANES; j++) begin
      pix[8*j +: 8] = brw_pkg::recon_pixel(
        (j < 4) ? work.res_left[16*(j%4) +: 16] : work.res_right[16*(j%4) +: 16],
        work.pred[8*j +: 8], work.intra);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_plane <= work.plane;
      s1_prod  <= brw_pkg::PROD_W'(work.line) * brw_pkg::PROD_W'(work.width);
      s1_col   <= work.col;
      s1_pix   <= pix;
    end
  end

  always_comb begin
    fill.plane_select = s1_plane;
    fill.row_address  = s1_prod[brw_pkg::ADDR_W-1:0] + brw_pkg::ADDR_W'(s1_col);
    fill.pixel_row    = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_mem[out_wr] <= fill;
    end
  end

  always_comb begin
    unique case ({s1_valid, deq})
      2'b10:   out_count_next = out_count + 1'b1;
      2'b01:   out_count_next = out_count - 1'b1;
      default: out_count_next = out_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      s1_valid <= take;
      if (s1_valid) begin
        out_wr <= out_wr + 1'b1;
      end
      if (deq) begin
        out_rd <= out_rd + 1'b1;
      end
      out_count <= out_count_next;
    end
  end

  assign empty  = (out_count == '0);
  assign result = out_mem[out_rd];

  `BRW_ASSERT_ALWAYS(a_credit, (out_count + brw_pkg::OUT_COUNT_W'(s1_valid)) <= brw_pkg::OUT_FULL)
  `BRW_ASSERT_NEXT(a_issue, take, s1_valid)
  `BRW_ASSERT_NEXT(a_drain, deq && !s1_valid, out_count == $past(out_count) - 1'b1)

endmodule

@@ rtl/core/block_reconstruct_writeback_core.sv @@
// MPEG-2 block row reconstruction. Each item is one 8-pixel row of an 8x8
// block; the block yields the target plane, the row's byte address within
// that plane and eight pixels clipped to 0..255. It takes one item per clock
// and returns one result per clock while the queues have room and results
// are popped. An item passes the classify queue, one address multiply stage
// and the result queue, each of which handles one item per clock unless
// held by a full queue downstream. Items with a block number above eleven
// are accepted and produce no result. Configuration writes (index 0 frame
// width, 1 chroma format, 2 picture structure) are always ready and must
// only be issued while no item is in flight.
module block_reconstruct_writeback_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  brw_pkg::req_t            request,
  output logic                     empty,
  input  logic                     pop,
  output brw_pkg::res_t            result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [brw_pkg::FW_W-1:0] cfg_data
);

  logic [brw_pkg::FW_W-1:0] frame_width;
  logic [1:0]               chroma_fmt;
  logic [1:0]               pic_struct;

  logic                     work_valid;
  brw_pkg::work_t           work;
  logic                     take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= brw_pkg::FW_W'(720);
      chroma_fmt  <= brw_pkg::CF_420;
      pic_struct  <= brw_pkg::PS_FRAME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        brw_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        brw_pkg::REG_CHROMA_FMT:  chroma_fmt  <= cfg_data[1:0];
        brw_pkg::REG_PIC_STRUCT:  pic_struct  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  brw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .request     (request),
    .frame_width (frame_width),
    .chroma_fmt  (chroma_fmt),
    .pic_struct  (pic_struct),
    .work_valid  (work_valid),
    .work        (work),
    .take        (take)
  );

  brw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
